// File: src/rpma_pkg.sv
// Shared constants and types for the RNS pointwise modular ALU.
`default_nettype none

package rpma_pkg;

  localparam int unsigned DEF_WORD_WIDTH  = 60;
  localparam int unsigned DEF_PRIME_COUNT = 4;

  // Configuration port: four modulus registers.
  localparam int unsigned REG_COUNT = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MOD_RESET = 2;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned SEL_W    = 2;

  typedef enum logic [OPCODE_W-1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2
  } op_e;

endpackage

`default_nettype wire

// File: src/rpma_if.sv
// Request and response channel interfaces of the modular ALU.
`default_nettype none

interface rpma_req_if #(
  parameter int unsigned WORD_WIDTH = rpma_pkg::DEF_WORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic [rpma_pkg::OPCODE_W-1:0] opcode;
  logic [rpma_pkg::SEL_W-1:0]    prime_index;
  logic [WORD_WIDTH-1:0]         operand_a;
  logic [WORD_WIDTH-1:0]         operand_b;

  modport source (output valid, opcode, prime_index, operand_a, operand_b, input ready);
  modport sink   (input valid, opcode, prime_index, operand_a, operand_b, output ready);
endinterface

interface rpma_rsp_if #(
  parameter int unsigned WORD_WIDTH = rpma_pkg::DEF_WORD_WIDTH
);
  logic                  valid;
  logic                  ready;
  logic [WORD_WIDTH-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

`default_nettype wire

// File: src/rpma_div_step.sv
// One restoring-division step reducing two operands modulo m, one bit each.
`default_nettype none

module rpma_div_step #(
  parameter int unsigned WORD_WIDTH = rpma_pkg::DEF_WORD_WIDTH
) (
  input  wire logic [WORD_WIDTH-1:0] m_i,
  input  wire logic [WORD_WIDTH-1:0] ra_i,
  input  wire logic [WORD_WIDTH-1:0] rb_i,
  input  wire logic                  bit_a_i,
  input  wire logic                  bit_b_i,
  output logic      [WORD_WIDTH-1:0] ra_o,
  output logic      [WORD_WIDTH-1:0] rb_o
);
  logic [WORD_WIDTH:0] ta, tb, mw;

  always_comb begin
    mw = {1'b0, m_i};
    ta = {ra_i, bit_a_i};
    tb = {rb_i, bit_b_i};
    if (ta >= mw) ta = ta - mw;
    if (tb >= mw) tb = tb - mw;
    // remainders stay below m, so the top bit is clear
    ra_o = ta[WORD_WIDTH-1:0];
    rb_o = tb[WORD_WIDTH-1:0];
  end
endmodule

`default_nettype wire

// File: src/rpma_mac_step.sv
// One double-and-add step of the modular multiply: acc = 2*acc + bit*x mod m.
`default_nettype none

module rpma_mac_step #(
  parameter int unsigned WORD_WIDTH = rpma_pkg::DEF_WORD_WIDTH
) (
  input  wire logic [WORD_WIDTH-1:0] m_i,
  input  wire logic [WORD_WIDTH-1:0] acc_i,
  input  wire logic [WORD_WIDTH-1:0] x_i,
  input  wire logic                  bit_i,
  output logic      [WORD_WIDTH-1:0] acc_o
);
  logic [WORD_WIDTH+1:0] t, m1, m2, d1, d2;

  always_comb begin
    // t < 3m: one of t, t-m, t-2m is the residue
    t  = {1'b0, acc_i, 1'b0} + (bit_i ? {2'b00, x_i} : '0);
    m1 = {2'b00, m_i};
    m2 = {1'b0, m_i, 1'b0};
    d1 = t - m1;
    d2 = t - m2;
    if (t >= m2)      acc_o = d2[WORD_WIDTH-1:0];
    else if (t >= m1) acc_o = d1[WORD_WIDTH-1:0];
    else              acc_o = t[WORD_WIDTH-1:0];
  end
endmodule

`default_nettype wire

// File: src/rpma_final.sv
// Final stage: picks the product or forms the modular sum or difference.
`default_nettype none

module rpma_final #(
  parameter int unsigned WORD_WIDTH = rpma_pkg::DEF_WORD_WIDTH
) (
  input  wire logic [rpma_pkg::OPCODE_W-1:0] opcode_i,
  input  wire logic                          zero_i,
  input  wire logic [WORD_WIDTH-1:0]         m_i,
  input  wire logic [WORD_WIDTH-1:0]         ra_i,
  input  wire logic [WORD_WIDTH-1:0]         rb_i,
  input  wire logic [WORD_WIDTH-1:0]         prod_i,
  output logic      [WORD_WIDTH-1:0]         result_o
);
  import rpma_pkg::*;

  logic [WORD_WIDTH:0]   sum, sum_m;
  logic [WORD_WIDTH-1:0] dif;

  always_comb begin
    sum   = {1'b0, ra_i} + {1'b0, rb_i};
    sum_m = sum - {1'b0, m_i};
    dif   = ra_i - rb_i;
    if (ra_i < rb_i) dif = dif + m_i;
    result_o = '0;
    if (!zero_i) begin
      unique case (opcode_i)
        OP_MUL:  result_o = prod_i;
        OP_ADD:  result_o = (sum >= {1'b0, m_i}) ? sum_m[WORD_WIDTH-1:0]
                                                 : sum[WORD_WIDTH-1:0];
        OP_SUB:  result_o = dif;
        default: result_o = '0;
      endcase
    end
  end
endmodule

`default_nettype wire

// File: src/rns_pointwise_modular_alu_unit.sv
// Top level of the RNS pointwise modular multiply/add/subtract unit.
// Each request carries an opcode (multiply, add, subtract), a prime index and
// two residues; the response is (a op b) mod modulus[prime_index], fully
// reduced even when the operands are not below the modulus. A request can be
// taken every cycle unless a stalled response holds the pipe, which is made of
// one input register, WORD_WIDTH restoring-division steps reducing both
// operands (one bit per stage), WORD_WIDTH double-and-add multiply steps (one
// multiplier bit per stage) and the output register. The whole pipe advances
// when the output register is empty or being taken, so a stalled response
// holds everything in place. Unused opcode, a prime index at or beyond
// PRIME_COUNT, or a zero modulus give a result of 0. Moduli must be written
// through the cfg port only while no request is in flight; the block does
// not enforce this. They reset to 2.
`default_nettype none

module rns_pointwise_modular_alu_unit #(
  parameter int unsigned WORD_WIDTH  = rpma_pkg::DEF_WORD_WIDTH,
  parameter int unsigned PRIME_COUNT = rpma_pkg::DEF_PRIME_COUNT
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  rpma_req_if.sink                            req_i,
  rpma_rsp_if.source                          rsp_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [rpma_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [WORD_WIDTH-1:0]          cfg_data_i
);
  import rpma_pkg::*;

  localparam int unsigned STEPS = 2 * WORD_WIDTH;

  // ---------------- modulus registers ----------------
  logic [WORD_WIDTH-1:0] mod_q [PRIME_COUNT];

  for (genvar i = 0; i < PRIME_COUNT; i++) begin : g_mod
    if (i < REG_COUNT) begin : g_wr
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mod_q[i] <= WORD_WIDTH'(MOD_RESET);
        end else if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(i)) begin
          mod_q[i] <= cfg_data_i;
        end
      end
    end else begin : g_fixed
      // never addressable by the config port
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mod_q[i] <= WORD_WIDTH'(MOD_RESET);
        end else begin
          mod_q[i] <= mod_q[i];
        end
      end
    end
  end

  // ---------------- pipeline ----------------
  // Global advance: output register free or being taken.
  logic adv;
  assign adv         = !rsp_o.valid || rsp_o.ready;
  assign req_i.ready = adv;

  // Entry lookup of the modulus.
  logic [WORD_WIDTH-1:0] m_sel;
  logic                  sel_hit;
  always_comb begin
    m_sel   = '0;
    sel_hit = 1'b0;
    for (int i = 0; i < PRIME_COUNT; i++) begin
      if (32'(req_i.prime_index) == i) begin
        m_sel   = mod_q[i];
        sel_hit = 1'b1;
      end
    end
  end

  // Stage k holds the item after k steps.
  logic                  vld_q  [STEPS+1];
  logic [OPCODE_W-1:0]   op_q   [STEPS+1];
  logic                  zero_q [STEPS+1];
  logic [WORD_WIDTH-1:0] m_q    [STEPS+1];
  logic [WORD_WIDTH-1:0] va_q   [STEPS+1]; // operand bits still to shift in
  logic [WORD_WIDTH-1:0] vb_q   [STEPS+1];
  logic [WORD_WIDTH-1:0] ra_q   [STEPS+1]; // reduced operands
  logic [WORD_WIDTH-1:0] rb_q   [STEPS+1];
  logic [WORD_WIDTH-1:0] acc_q  [STEPS+1]; // product accumulator

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q[0]   <= req_i.opcode;
      zero_q[0] <= !sel_hit || (m_sel == '0) ||
                   !((req_i.opcode == OP_MUL) || (req_i.opcode == OP_ADD) ||
                     (req_i.opcode == OP_SUB));
      m_q[0]    <= m_sel;
      va_q[0]   <= req_i.operand_a;
      vb_q[0]   <= req_i.operand_b;
      ra_q[0]   <= '0;
      rb_q[0]   <= '0;
      acc_q[0]  <= '0;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic [WORD_WIDTH-1:0] ra_d, rb_d, acc_d, va_d, vb_d;

    if (k < WORD_WIDTH) begin : g_div
      rpma_div_step #(.WORD_WIDTH(WORD_WIDTH)) u_div (
        .m_i    (m_q[k]),
        .ra_i   (ra_q[k]),
        .rb_i   (rb_q[k]),
        .bit_a_i(va_q[k][WORD_WIDTH-1]),
        .bit_b_i(vb_q[k][WORD_WIDTH-1]),
        .ra_o   (ra_d),
        .rb_o   (rb_d)
      );
      assign va_d  = {va_q[k][WORD_WIDTH-2:0], 1'b0};
      assign vb_d  = {vb_q[k][WORD_WIDTH-2:0], 1'b0};
      assign acc_d = '0;
    end else begin : g_mac
      // first multiply step reloads the multiplier from the reduced b
      logic [WORD_WIDTH-1:0] mb;
      assign mb = (k == WORD_WIDTH) ? rb_q[k] : vb_q[k];
      rpma_mac_step #(.WORD_WIDTH(WORD_WIDTH)) u_mac (
        .m_i  (m_q[k]),
        .acc_i(acc_q[k]),
        .x_i  (ra_q[k]),
        .bit_i(mb[WORD_WIDTH-1]),
        .acc_o(acc_d)
      );
      assign ra_d = ra_q[k];
      assign rb_d = rb_q[k];
      assign va_d = va_q[k];
      assign vb_d = {mb[WORD_WIDTH-2:0], 1'b0};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        op_q[k+1]   <= op_q[k];
        zero_q[k+1] <= zero_q[k];
        m_q[k+1]    <= m_q[k];
        va_q[k+1]   <= va_d;
        vb_q[k+1]   <= vb_d;
        ra_q[k+1]   <= ra_d;
        rb_q[k+1]   <= rb_d;
        acc_q[k+1]  <= acc_d;
      end
    end
  end

  // ---------------- output register ----------------
  logic [WORD_WIDTH-1:0] res_d, res_q;
  logic                  out_vld_q;

  rpma_final #(.WORD_WIDTH(WORD_WIDTH)) u_final (
    .opcode_i(op_q[STEPS]),
    .zero_i  (zero_q[STEPS]),
    .m_i     (m_q[STEPS]),
    .ra_i    (ra_q[STEPS]),
    .rb_i    (rb_q[STEPS]),
    .prod_i  (acc_q[STEPS]),
    .result_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.result = res_q;

endmodule

`default_nettype wire
